// File: hw/rtl/ecgrr_pkg.sv
// Shared constants, types and helper functions of the ECG R-peak and RR detector.
package ecgrr_pkg;

  // Storage sizes.
  localparam int unsigned WindowDepth = 8192;
  localparam int unsigned WinAw       = $clog2(WindowDepth);
  localparam int unsigned RawDepth    = 16384;
  localparam int unsigned RawAw       = $clog2(RawDepth);
  localparam int unsigned RrTaps      = 8;
  localparam int unsigned RrPtrW      = $clog2(RrTaps);
  localparam int unsigned RrSumW      = 16 + RrPtrW;
  localparam int unsigned FifoDepth   = 2;
  localparam int unsigned FifoAw      = $clog2(FifoDepth);
  localparam int unsigned DivW        = 32;
  localparam int unsigned DivCntW     = $clog2(DivW);

  // Field widths.
  localparam int unsigned RateW = 10;
  localparam int unsigned RrW   = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  // Fixed values.
  localparam logic [RateW-1:0] RateReset  = 10'd250;
  localparam logic [RrW-1:0]   MinRrReset = 16'd30;
  localparam logic [RrW-1:0]   MaxRrReset = 16'd6000;
  localparam logic [RrW-1:0]   RrReset    = 16'd220;
  localparam logic [7:0]       Baseline   = 8'd127;
  localparam logic [7:0]       RawMax     = 8'd255;
  localparam int unsigned      SecPerMin  = 60;
  localparam logic [RrSumW-1:0] RrSumReset = RrSumW'(RrTaps * 220);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_RATE = 2'd0,
    CFG_MIN_RR      = 2'd1,
    CFG_MAX_RR      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_LAST,
    B_CONF,
    B_DIV,
    B_DONE
  } back_state_e;

  // One classified sample handed from the front to the back part.
  typedef struct packed {
    logic [7:0]       raw;
    logic [RawAw-1:0] raw_addr;
    logic             search;
    logic [31:0]      rise_pos;
    logic [31:0]      fall_pos;
    logic [31:0]      packet;
  } job_t;

  // Distance of a raw sample from the fixed baseline.
  function automatic logic [7:0] dist_base(input logic [7:0] v);
    return (v >= Baseline) ? (v - Baseline) : (Baseline - v);
  endfunction

  // Sample rate with zero taken as one.
  function automatic logic [RateW-1:0] eff_rate(input logic [RateW-1:0] r);
    return (r == '0) ? RateW'(1) : r;
  endfunction

endpackage

// File: hw/rtl/ecgrr_if.sv
// Request channel interfaces of the detector: sample input and beat result output.
interface ecgrr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] energy_sample;
  logic [7:0]  raw_sample;
  logic [31:0] packet_count;

  modport source (output valid, energy_sample, raw_sample, packet_count, input ready);
  modport sink   (input valid, energy_sample, raw_sample, packet_count, output ready);
endinterface

interface ecgrr_out_if;
  logic        valid;
  logic        ready;
  logic        beat_found;
  logic [31:0] rr_start;
  logic [31:0] rr_length;
  logic        inverted;
  logic        abnormal;
  logic [15:0] heart_rate;
  logic [31:0] beat_packet;

  modport source (output valid, beat_found, rr_start, rr_length, inverted, abnormal,
                  heart_rate, beat_packet, input ready);
  modport sink   (input valid, beat_found, rr_start, rr_length, inverted, abnormal,
                  heart_rate, beat_packet, output ready);
endinterface

// File: hw/rtl/ecgrr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module ecgrr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ecgrr_pkg::DivW-1:0]    dividend_i,
  input  logic [ecgrr_pkg::DivW-1:0]    divisor_i,
  output logic                          done_o,
  output logic [ecgrr_pkg::DivW-1:0]    quotient_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [ecgrr_pkg::DivCntW-1:0]    cnt_q, cnt_d;
  logic [ecgrr_pkg::DivW-1:0]       rem_q, rem_d;
  logic [ecgrr_pkg::DivW-1:0]       quo_q, quo_d;
  logic [ecgrr_pkg::DivW-1:0]       dvs_q, dvs_d;
  logic [ecgrr_pkg::DivW:0]         rem_sh;
  logic [ecgrr_pkg::DivW:0]         rem_sub;
  logic                             ge;

  // One shift-subtract step.
  always_comb begin
    rem_sh  = {rem_q, quo_q[ecgrr_pkg::DivW-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[ecgrr_pkg::DivW-1:0] : rem_sh[ecgrr_pkg::DivW-1:0];
      quo_d = {quo_q[ecgrr_pkg::DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: hw/rtl/ecgrr_front.sv
// Front part: window delay line, mean threshold and rise/fall classification.
module ecgrr_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ecgrr_in_if.sink                          in_if,
  input  logic [ecgrr_pkg::RateW-1:0]       sample_rate_i,
  output logic                              push_o,
  output ecgrr_pkg::job_t                   job_o,
  input  logic                              full_i
);

  ecgrr_pkg::front_state_e state_q, state_d;

  logic [15:0] energy_mem [ecgrr_pkg::WindowDepth];

  logic [31:0]             idx_q;
  logic [31:0]             sum_q;
  logic                    above_q;
  logic [31:0]             rise_q;
  logic                    rise_v_q;
  logic [15:0]             old_q;
  logic                    win_rdy_q;
  logic [31:0]             len_q;
  ecgrr_pkg::job_t         job_q;

  logic [31:0] len8;
  logic [31:0] win_len;
  logic        accept;
  logic        div_start;
  logic        div_done;
  logic [31:0] quot;
  logic [31:0] thr;
  logic [31:0] fall_pos;

  // Window length: eight seconds, limited by the delay line.
  always_comb begin
    len8    = {19'd0, ecgrr_pkg::eff_rate(sample_rate_i), 3'b000};
    win_len = (len8 > 32'(ecgrr_pkg::WindowDepth)) ? 32'(ecgrr_pkg::WindowDepth) : len8;
  end

  assign thr      = {1'b0, quot[31:1]};
  assign fall_pos = idx_q - len_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ecgrr_pkg::F_IDLE: if (in_if.valid) state_d = ecgrr_pkg::F_READ;
      ecgrr_pkg::F_READ: state_d = win_rdy_q ? ecgrr_pkg::F_DIV : ecgrr_pkg::F_PUSH;
      ecgrr_pkg::F_DIV:  if (div_done) state_d = ecgrr_pkg::F_PUSH;
      ecgrr_pkg::F_PUSH: if (!full_i) state_d = ecgrr_pkg::F_IDLE;
      default:           state_d = ecgrr_pkg::F_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_if.ready = 1'b0;
    div_start   = 1'b0;
    push_o      = 1'b0;
    case (state_q)
      ecgrr_pkg::F_IDLE: in_if.ready = 1'b1;
      ecgrr_pkg::F_READ: div_start   = win_rdy_q;
      ecgrr_pkg::F_PUSH: push_o      = !full_i;
      default: ;
    endcase
  end

  assign accept = in_if.valid & in_if.ready;
  assign job_o  = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ecgrr_pkg::F_IDLE;
    else         state_q <= state_d;
  end

  // Delay line: old value read before the new one lands.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      old_q <= energy_mem[idx_q[ecgrr_pkg::WinAw-1:0] - win_len[ecgrr_pkg::WinAw-1:0]];
      energy_mem[idx_q[ecgrr_pkg::WinAw-1:0]] <= in_if.energy_sample;
    end
  end

  // Payload of the job under work.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      len_q            <= win_len;
      win_rdy_q        <= idx_q >= win_len;
      job_q.raw        <= in_if.raw_sample;
      job_q.raw_addr   <= idx_q[ecgrr_pkg::RawAw-1:0];
      job_q.search     <= 1'b0;
      job_q.rise_pos   <= '0;
      job_q.fall_pos   <= '0;
      job_q.packet     <= in_if.packet_count;
    end else if (state_q == ecgrr_pkg::F_DIV && div_done && {16'd0, old_q} <= thr &&
                 rise_v_q && fall_pos > rise_q) begin
      job_q.search   <= 1'b1;
      job_q.rise_pos <= rise_q;
      job_q.fall_pos <= fall_pos;
    end
  end

  // Running window sum and threshold crossing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      sum_q    <= '0;
      above_q  <= 1'b0;
      rise_q   <= '0;
      rise_v_q <= 1'b0;
    end else begin
      if (accept) sum_q <= sum_q + {16'd0, in_if.energy_sample};
      if (state_q == ecgrr_pkg::F_DIV && div_done) begin
        sum_q <= sum_q - {16'd0, old_q};
        if ({16'd0, old_q} > thr) begin
          if (!above_q && !rise_v_q) begin
            rise_q   <= fall_pos;
            rise_v_q <= 1'b1;
          end
          above_q <= 1'b1;
        end else begin
          above_q <= 1'b0;
          if (rise_v_q && fall_pos > rise_q) rise_v_q <= 1'b0;
        end
      end
      if (push_o) idx_q <= idx_q + 32'd1;
    end
  end

  ecgrr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

endmodule

// File: hw/rtl/ecgrr_fifo.sv
// Short job queue between the front and the back part.
module ecgrr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ecgrr_pkg::job_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ecgrr_pkg::job_t data_o
);

  ecgrr_pkg::job_t               slot_q [ecgrr_pkg::FifoDepth];
  logic [ecgrr_pkg::FifoAw-1:0]  wr_q, rd_q;
  logic [ecgrr_pkg::FifoAw:0]    cnt_q;

  assign full_o  = cnt_q == (ecgrr_pkg::FifoAw+1)'(ecgrr_pkg::FifoDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (ecgrr_pkg::FifoAw+1)'(push_i) - (ecgrr_pkg::FifoAw+1)'(pop_i);
    end
  end

endmodule

// File: hw/rtl/ecgrr_back.sv
// Back part: raw history, peak search, RR interval forming and heart rate.
module ecgrr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  ecgrr_pkg::job_t               job_i,
  output logic                          pop_o,
  input  logic [ecgrr_pkg::RateW-1:0]   sample_rate_i,
  input  logic [ecgrr_pkg::RrW-1:0]     min_rr_i,
  input  logic [ecgrr_pkg::RrW-1:0]     max_rr_i,
  ecgrr_out_if.source                   out_if
);

  ecgrr_pkg::back_state_e state_q, state_d;

  logic [7:0] raw_mem [ecgrr_pkg::RawDepth];

  ecgrr_pkg::job_t                job_q;
  logic [31:0]                    pos_q;
  logic [ecgrr_pkg::RawAw-1:0]    left_q;
  logic [7:0]                     rd_q;
  logic [31:0]                    rd_pos_q;
  logic                           rd_v_q;
  logic [7:0]                     maxv_q, minv_q;
  logic [31:0]                    max_idx_q, min_idx_q;
  logic [31:0]                    last_r_q, last_len_q;
  logic [ecgrr_pkg::RrW-1:0]      ring_q [ecgrr_pkg::RrTaps];
  logic [ecgrr_pkg::RrPtrW-1:0]   ptr_q;
  logic [ecgrr_pkg::RrSumW-1:0]   rsum_q;
  logic                           dvs_zero_q;

  logic                           res_beat_q, res_inv_q, res_abn_q;
  logic [31:0]                    res_start_q, res_len_q, res_pkt_q;
  logic [15:0]                    res_hr_q;
  logic                           ov_q;

  // Scan bounds of the job at the head of the queue.
  logic [31:0] span, lo_a, lo;
  logic [31:0] cnt_m1;
  logic        pop;

  // Beat decision.
  logic [7:0]                   dmax, dmin;
  logic                         inv;
  logic [31:0]                  rpos, dlt, start, len;
  logic                         stale, abn;
  logic [ecgrr_pkg::RrSumW-1:0] sum_new;
  logic [31:0]                  dvd, dvs;
  logic                         div_start, div_done;
  logic [31:0]                  quot;
  logic [ecgrr_pkg::RateW-1:0]  rate;
  logic                         out_free;

  assign out_free = !ov_q || out_if.ready;

  always_comb begin
    span   = job_i.fall_pos - job_i.rise_pos;
    lo_a   = (job_i.rise_pos >= span) ? (job_i.rise_pos - span) : 32'd0;
    lo     = (job_i.rise_pos - lo_a >= 32'(ecgrr_pkg::RawDepth)) ?
             (job_i.rise_pos - 32'(ecgrr_pkg::RawDepth - 1)) : lo_a;
    cnt_m1 = job_i.rise_pos - lo;
  end

  always_comb begin
    rate    = ecgrr_pkg::eff_rate(sample_rate_i);
    dmax    = ecgrr_pkg::dist_base(maxv_q);
    dmin    = ecgrr_pkg::dist_base(minv_q);
    inv     = (last_len_q != '0) && ({1'b0, dmin} > {dmax, 1'b0});
    rpos    = inv ? min_idx_q : max_idx_q;
    dlt     = rpos - last_r_q - last_len_q;
    stale   = (last_r_q == '0) || (rpos == last_r_q) || (dlt == '0) || dlt[31];
    start   = (last_len_q < {16'd0, min_rr_i}) ? last_r_q : (last_r_q + last_len_q);
    len     = rpos - start;
    abn     = len > {16'd0, max_rr_i};
    sum_new = rsum_q - ecgrr_pkg::RrSumW'(ring_q[ptr_q]) + ecgrr_pkg::RrSumW'(len[15:0]);
    dvd     = abn ? 32'(32'(rate) * ecgrr_pkg::SecPerMin) :
                    32'(32'(rate) * (ecgrr_pkg::SecPerMin * ecgrr_pkg::RrTaps));
    dvs     = abn ? len : 32'(sum_new);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ecgrr_pkg::B_IDLE: begin
        if (!empty_i) state_d = job_i.search ? ecgrr_pkg::B_SCAN : ecgrr_pkg::B_DONE;
      end
      ecgrr_pkg::B_SCAN: if (left_q == '0) state_d = ecgrr_pkg::B_LAST;
      ecgrr_pkg::B_LAST: state_d = ecgrr_pkg::B_CONF;
      ecgrr_pkg::B_CONF: state_d = stale ? ecgrr_pkg::B_DONE : ecgrr_pkg::B_DIV;
      ecgrr_pkg::B_DIV:  if (div_done) state_d = ecgrr_pkg::B_DONE;
      ecgrr_pkg::B_DONE: if (out_free) state_d = ecgrr_pkg::B_IDLE;
      default:           state_d = ecgrr_pkg::B_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ecgrr_pkg::B_IDLE: pop       = !empty_i;
      ecgrr_pkg::B_CONF: div_start = !stale;
      default: ;
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ecgrr_pkg::B_IDLE;
    else         state_q <= state_d;
  end

  // Raw history: the new sample is written before the search reads.
  always_ff @(posedge clk_i) begin
    if (pop) raw_mem[job_i.raw_addr] <= job_i.raw;
    if (state_q == ecgrr_pkg::B_SCAN) rd_q <= raw_mem[pos_q[ecgrr_pkg::RawAw-1:0]];
    rd_pos_q <= pos_q;
  end

  // Scan address walk and job capture.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      job_q  <= job_i;
      pos_q  <= lo;
      left_q <= cnt_m1[ecgrr_pkg::RawAw-1:0];
    end else if (state_q == ecgrr_pkg::B_SCAN) begin
      pos_q  <= pos_q + 32'd1;
      left_q <= left_q - 1'b1;
    end
  end

  // Running maximum and minimum; the indexes persist between searches.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q    <= 1'b0;
      maxv_q    <= '0;
      minv_q    <= ecgrr_pkg::RawMax;
      max_idx_q <= '0;
      min_idx_q <= '0;
    end else begin
      rd_v_q <= state_q == ecgrr_pkg::B_SCAN;
      if (pop) begin
        maxv_q <= '0;
        minv_q <= ecgrr_pkg::RawMax;
      end else if (rd_v_q) begin
        if (rd_q > maxv_q) begin
          maxv_q    <= rd_q;
          max_idx_q <= rd_pos_q;
        end
        if (rd_q < minv_q) begin
          minv_q    <= rd_q;
          min_idx_q <= rd_pos_q;
        end
      end
    end
  end

  // Beat history: previous R, interval ring and its sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_r_q   <= '0;
      last_len_q <= '0;
      ptr_q      <= '0;
      rsum_q     <= ecgrr_pkg::RrSumReset;
      for (int i = 0; i < ecgrr_pkg::RrTaps; i++) ring_q[i] <= ecgrr_pkg::RrReset;
    end else if (state_q == ecgrr_pkg::B_CONF) begin
      if (last_r_q == '0) begin
        if (rpos != '0) last_r_q <= rpos;
      end else if (!stale) begin
        last_r_q   <= start;
        last_len_q <= len;
        if (!abn) begin
          ring_q[ptr_q] <= len[15:0];
          ptr_q         <= ptr_q + 1'b1;
          rsum_q        <= sum_new;
        end
      end
    end
  end

  // Result under construction.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_beat_q  <= 1'b0;
      res_start_q <= '0;
      res_len_q   <= '0;
      res_inv_q   <= 1'b0;
      res_abn_q   <= 1'b0;
      res_hr_q    <= '0;
      res_pkt_q   <= '0;
    end else if (state_q == ecgrr_pkg::B_CONF && !stale) begin
      res_beat_q  <= 1'b1;
      res_start_q <= start;
      res_len_q   <= len;
      res_inv_q   <= inv;
      res_abn_q   <= abn;
      res_pkt_q   <= abn ? 32'd0 : job_q.packet;
      dvs_zero_q  <= dvs == '0;
    end else if (state_q == ecgrr_pkg::B_DIV && div_done) begin
      res_hr_q <= dvs_zero_q ? 16'd0 : quot[15:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == ecgrr_pkg::B_DONE && out_free) begin
      ov_q <= 1'b1;
    end else if (out_if.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ecgrr_pkg::B_DONE && out_free) begin
      out_if.beat_found  <= res_beat_q;
      out_if.rr_start    <= res_start_q;
      out_if.rr_length   <= res_len_q;
      out_if.inverted    <= res_inv_q;
      out_if.abnormal    <= res_abn_q;
      out_if.heart_rate  <= res_hr_q;
      out_if.beat_packet <= res_pkt_q;
    end
  end

  assign out_if.valid = ov_q;

  ecgrr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quot)
  );

endmodule

// File: hw/rtl/ecg_r_peak_rr_detector_core.sv
// Top level of the ECG R-peak and RR-interval detector.
//
//   Channel  | Direction | Payload
//   ---------+-----------+------------------------------------------------------
//   in_if    | sink      | energy_sample[15:0], raw_sample[7:0], packet_count[31:0]
//   out_if   | source    | beat_found, rr_start, rr_length, inverted, abnormal,
//            |           | heart_rate[15:0], beat_packet[31:0]
//   cfg      | write     | cfg_we_i, cfg_idx_i[1:0], cfg_data_i[15:0]
//
// The front part takes one sample at a time: it reads the window, runs its 32-step
// threshold divider once the window is full and pushes the job, holding while the
// queue is full. The back part passes a sample without a search straight to its result;
// on a fall it makes one raw history read per cycle over the searched span, at most
// RawDepth samples, then runs the 32-step heart rate divider unless no interval is formed.
// A two-entry queue between the parts lets each stall on its own; no clearing pass
// follows reset. One result request is produced per accepted sample.
module ecg_r_peak_rr_detector_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ecgrr_in_if.sink                        in_if,
  ecgrr_out_if.source                     out_if,
  input  logic                            cfg_we_i,
  input  logic [ecgrr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ecgrr_pkg::CfgW-1:0]      cfg_data_i
);

  logic [ecgrr_pkg::RateW-1:0] rate_q;
  logic [ecgrr_pkg::RrW-1:0]   min_rr_q, max_rr_q;

  logic            push, full, pop, empty;
  ecgrr_pkg::job_t job_in, job_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= ecgrr_pkg::RateReset;
      min_rr_q <= ecgrr_pkg::MinRrReset;
      max_rr_q <= ecgrr_pkg::MaxRrReset;
    end else if (cfg_we_i) begin
      case (ecgrr_pkg::cfg_idx_e'(cfg_idx_i))
        ecgrr_pkg::CFG_SAMPLE_RATE: rate_q   <= cfg_data_i[ecgrr_pkg::RateW-1:0];
        ecgrr_pkg::CFG_MIN_RR:      min_rr_q <= cfg_data_i;
        ecgrr_pkg::CFG_MAX_RR:      max_rr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ecgrr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_if         (in_if),
    .sample_rate_i (rate_q),
    .push_o        (push),
    .job_o         (job_in),
    .full_i        (full)
  );

  ecgrr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (job_out)
  );

  ecgrr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .job_i         (job_out),
    .pop_o         (pop),
    .sample_rate_i (rate_q),
    .min_rr_i      (min_rr_q),
    .max_rr_i      (max_rr_q),
    .out_if        (out_if)
  );

endmodule

// File: hw/rtl/ecgrr_checker.sv
// Port-level checks of the detector and their attachment to the top level.
module ecgrr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        beat_found_i,
  input logic [31:0] rr_start_i,
  input logic [31:0] rr_length_i,
  input logic        inverted_i,
  input logic        abnormal_i,
  input logic [15:0] heart_rate_i,
  input logic [31:0] beat_packet_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(rr_start_i) && $stable(rr_length_i) &&
    $stable(heart_rate_i) && $stable(beat_packet_i))
    else $error("result payload changed while stalled");

  // Without a beat every other field is zero.
  a_no_beat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !beat_found_i |-> rr_start_i == '0 && rr_length_i == '0 &&
    !inverted_i && !abnormal_i && heart_rate_i == '0 && beat_packet_i == '0)
    else $error("fields set on a result without a beat");

  // An abnormal beat carries no packet and has a nonzero length.
  a_abnormal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && abnormal_i |-> beat_packet_i == '0 && rr_length_i != '0)
    else $error("abnormal beat with packet or zero length");

endmodule

bind ecg_r_peak_rr_detector_core ecgrr_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .beat_found_i  (out_if.beat_found),
  .rr_start_i    (out_if.rr_start),
  .rr_length_i   (out_if.rr_length),
  .inverted_i    (out_if.inverted),
  .abnormal_i    (out_if.abnormal),
  .heart_rate_i  (out_if.heart_rate),
  .beat_packet_i (out_if.beat_packet)
);
